FILE: hdl/pbps_pkg.sv
// ----------------------------------------------------------------------------
// pbps_pkg
// Shared sizes, codes and lookup table of the paletted bit-packed store.
// ----------------------------------------------------------------------------
package pbps_pkg;

    // store sizes
    localparam int MAX_ENTRIES   = 4096;
    localparam int PALETTE_DEPTH = 256;
    localparam int WORD_DEPTH    = 2048;

    localparam int ENT_AW  = $clog2(MAX_ENTRIES);
    localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
    localparam int WORD_AW = $clog2(WORD_DEPTH);

    // field widths
    localparam int MODE_W  = 3;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 12;
    localparam int DATA_W  = 64;
    localparam int ERR_W   = 2;
    localparam int ENC_W   = 2;
    localparam int BITS_W  = 6;
    localparam int PCNT_W  = 9;
    localparam int WCNT_W  = 12;
    localparam int SIZE_W  = 13;
    localparam int PER_W   = 7;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 13;

    // distinct value limits, already bounded by the palette store depth
    localparam logic [PCNT_W-1:0] LIMIT_BLOCK =
        PCNT_W'((PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256);
    localparam logic [PCNT_W-1:0] LIMIT_BIOME =
        PCNT_W'((PALETTE_DEPTH < 8) ? PALETTE_DEPTH : 8);

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD     = 3'd0,
        MODE_FINALIZE = 3'd1,
        MODE_RD_VALUE = 3'd2,
        MODE_RD_WORD  = 3'd3,
        MODE_RD_PAL   = 3'd4,
        MODE_FILL     = 3'd5
    } t_mode;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_COUNT = 2'd2
    } t_err;

    typedef enum logic [ENC_W-1:0] {
        ENC_SINGLE   = 2'd0,
        ENC_INDIRECT = 2'd1,
        ENC_DIRECT   = 2'd2
    } t_enc;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_ENTRIES   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_KIND      = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_BLOCK_MIN = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_BLOCK_MAX = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_BIOME_MIN = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_BIOME_MAX = 3'd5;

    // entries per 64-bit word, indexed by entry width
    localparam logic [PER_W-1:0] PER_TAB [0:32] = '{
        7'd64, 7'd64, 7'd32, 7'd21, 7'd16, 7'd12, 7'd10, 7'd9, 7'd8,
        7'd7,  7'd6,  7'd5,  7'd5,  7'd4,  7'd4,  7'd4,  7'd4,
        7'd3,  7'd3,  7'd3,  7'd3,  7'd3,
        7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,
        7'd2,  7'd2,  7'd2
    };

    // smallest n with 2**n >= c
    function automatic logic [3:0] ceil_log2(input logic [PCNT_W-1:0] c);
        logic [3:0] r;
        r = '0;
        for (int n = 0; n < 9; n++) begin
            if ((PCNT_W'(1) << n) < c) begin
                r = 4'(n + 1);
            end
        end
        return r;
    endfunction

endpackage

FILE: hdl/pbps_if.sv
// ----------------------------------------------------------------------------
// pbps_item_if / pbps_result_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface pbps_item_if
    import pbps_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] item_value;
    logic [INDEX_W-1:0] item_index;

    modport source (output valid, mode, item_value, item_index, input ready);
    modport sink   (input valid, mode, item_value, item_index, output ready);
endinterface

interface pbps_result_if
    import pbps_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic [ERR_W-1:0]  error_code;
    logic [ENC_W-1:0]  encoding_kind;
    logic [BITS_W-1:0] entry_bits;
    logic [PCNT_W-1:0] palette_size;
    logic [WCNT_W-1:0] word_total;

    modport source (output valid, read_data, error_code, encoding_kind, entry_bits,
                    palette_size, word_total, input ready);
    modport sink   (input valid, read_data, error_code, encoding_kind, entry_bits,
                    palette_size, word_total, output ready);
endinterface

FILE: hdl/palette_bit_packed_store_core.sv
// ----------------------------------------------------------------------------
// palette_bit_packed_store_core
// Paletted container: raw value store, palette builder and bit packer.
// ----------------------------------------------------------------------------
// Command words enter on i_item, one result word per command leaves on
// o_result. Configuration is written through i_cfg_we/i_cfg_index/
// i_cfg_data; the user must write it only while no command is in flight,
// as the block does not enforce this. One command is worked at a time:
//   load, fill single, unused modes : straight to the result hand-off
//   read word, read palette         : a memory read, then the hand-off
//   read value                      : palette read if single, else a 12-step
//                                     serial divide of the entry index, word
//                                     read, extract, indirect palette read
//   finalize                        : per-entry palette search, then packing
// The finalize time is set by the single read port of the palette memory,
// which the first-appearance search walks one slot a cycle.
// The result register lets the next command be taken while a result waits;
// a finished command then holds until the receiver takes the waiting word.
// Reset clears all control state and the configuration to its defaults; the
// memories need no clearing pass (palette entry zero reads as zero until it
// is written, packed words are rebuilt whole at each finalize).
// ----------------------------------------------------------------------------
module palette_bit_packed_store_core
    import pbps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_IW-1:0]  i_cfg_index,
    input  logic [CFG_DW-1:0]  i_cfg_data,
    pbps_item_if.sink          i_item,
    pbps_result_if.source      o_result
);

    typedef enum logic [3:0] {
        S_IDLE, S_DONE, S_FA_RD, S_FA_CMP, S_FIN_DEC, S_FB_RD, S_FB_ACC,
        S_RV_DIV, S_RV_CHK, S_RV_EXT, S_WORD_OUT, S_PAL_OUT
    } t_state;

    // configuration registers
    logic [SIZE_W-1:0] r_entries;
    logic              r_kind;
    logic [3:0]        r_blk_min, r_bio_min;
    logic [5:0]        r_blk_max, r_bio_max;

    // container state
    logic [ENC_W-1:0]  r_enc;
    logic [BITS_W-1:0] r_bits;
    logic [PCNT_W-1:0] r_pal_cnt;
    logic [WCNT_W-1:0] r_word_cnt;
    logic [SIZE_W-1:0] r_load_pos;
    logic              r_p0_valid;

    // sequencer
    t_state             r_state;
    logic [ENT_AW-1:0]  r_i;
    logic [PCNT_W-1:0]  r_j, r_cnt;
    logic               r_ovf;
    logic [WORD_AW-1:0] r_w;
    logic [PER_W-1:0]   r_slot, r_per;
    logic [5:0]         r_off;
    logic [DATA_W-1:0]  r_word;
    logic [INDEX_W-1:0] r_q;
    logic [PER_W-1:0]   r_rem;
    logic [3:0]         r_k;
    logic [DATA_W-1:0]  r_res_data;
    logic [ERR_W-1:0]   r_res_err;

    // result register
    logic               r_ov;
    logic [DATA_W-1:0]  r_o_data;
    logic [ERR_W-1:0]   r_o_err;
    logic [ENC_W-1:0]   r_o_enc;
    logic [BITS_W-1:0]  r_o_bits;
    logic [PCNT_W-1:0]  r_o_pal;
    logic [WCNT_W-1:0]  r_o_words;

    // memory ports
    logic                raw_we, raw_re, idx_we, idx_re, pal_we, pal_re, pk_we, pk_re;
    logic [ENT_AW-1:0]   raw_wa, raw_ra, idx_wa, idx_ra;
    logic [VALUE_W-1:0]  raw_wd, raw_rd, pal_wd, pal_rd;
    logic [PAL_AW-1:0]   idx_wd, idx_rd, pal_wa, pal_ra;
    logic [WORD_AW-1:0]  pk_wa, pk_ra;
    logic [DATA_W-1:0]   pk_wd, pk_rd;
    logic                r_pal_zero;

    logic [VALUE_W-1:0] raw_mem [MAX_ENTRIES];
    logic [PAL_AW-1:0]  idx_mem [MAX_ENTRIES];
    logic [VALUE_W-1:0] pal_mem [PALETTE_DEPTH];
    logic [DATA_W-1:0]  pk_mem  [WORD_DEPTH];

    // derived values
    logic [SIZE_W-1:0]  size;
    logic [PCNT_W-1:0]  limit;
    logic [BITS_W-1:0]  minb, maxb, need, new_bits;
    logic [3:0]         min_raw;
    logic [5:0]         max_raw;
    logic               in_fire, last_i, fa_hit, fa_miss, fa_adv, slot_free;
    logic [VALUE_W-1:0] pal_out, mask32, pack_v, ext_v;
    logic [DATA_W-1:0]  word_next, ext_sh;
    logic               fb_flush, fb_done;
    logic [PER_W-1:0]   rem_sh;
    logic               div_ge;
    logic [11:0]        off_full;
    logic [32:0]        mask33;

    assign in_fire        = i_item.valid && i_item.ready;
    assign i_item.ready   = (r_state == S_IDLE);
    assign slot_free      = !r_ov || o_result.ready;

    // effective size and width limits
    always_comb begin
        if (r_entries == '0) begin
            size = SIZE_W'(1);
        end else if (r_entries > SIZE_W'(MAX_ENTRIES)) begin
            size = SIZE_W'(MAX_ENTRIES);
        end else begin
            size = r_entries;
        end
        limit   = r_kind ? LIMIT_BLOCK : LIMIT_BIOME;
        min_raw = r_kind ? r_blk_min : r_bio_min;
        max_raw = r_kind ? r_blk_max : r_bio_max;
        minb    = (min_raw == '0) ? BITS_W'(1) : {2'b00, min_raw};
        if (max_raw == '0) begin
            maxb = BITS_W'(1);
        end else if (max_raw > 6'd32) begin
            maxb = BITS_W'(32);
        end else begin
            maxb = max_raw;
        end
        need     = {2'b00, ceil_log2(r_cnt)};
        new_bits = (need < maxb) ? need : maxb;
        if (new_bits < minb) begin
            new_bits = minb;
        end
    end

    // palette search, packing and read-value datapath
    always_comb begin
        pal_out   = r_pal_zero ? '0 : pal_rd;
        last_i    = ({1'b0, r_i} + SIZE_W'(1)) == size;
        fa_miss   = (r_j == r_cnt);
        fa_hit    = !fa_miss && (pal_out == raw_rd);
        fa_adv    = fa_hit || (fa_miss && (r_cnt < limit));
        mask33    = (33'd1 << r_bits) - 33'd1;
        mask32    = mask33[31:0];
        pack_v    = ((r_enc == ENC_INDIRECT) ? VALUE_W'(idx_rd) : raw_rd) & mask32;
        word_next = r_word | (DATA_W'(pack_v) << r_off);
        fb_flush  = ((r_slot + PER_W'(1)) == r_per) || last_i;
        fb_done   = last_i || (fb_flush && (r_w == WORD_AW'(WORD_DEPTH - 1)));
        rem_sh    = {r_rem[5:0], r_q[INDEX_W-1]};
        div_ge    = rem_sh >= r_per;
        off_full  = r_rem[5:0] * r_bits;
        ext_sh    = pk_rd >> r_off;
        ext_v     = ext_sh[31:0] & mask32;
    end

    // memory port control
    always_comb begin
        raw_we = 1'b0; raw_wa = '0; raw_wd = '0; raw_re = 1'b0; raw_ra = '0;
        idx_we = 1'b0; idx_wa = '0; idx_wd = '0; idx_re = 1'b0; idx_ra = '0;
        pal_we = 1'b0; pal_wa = '0; pal_wd = '0; pal_re = 1'b0; pal_ra = '0;
        pk_we  = 1'b0; pk_wa  = '0; pk_wd  = '0; pk_re  = 1'b0; pk_ra  = '0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_item.mode)
                        MODE_LOAD: begin
                            raw_we = r_load_pos < size;
                            raw_wa = r_load_pos[ENT_AW-1:0];
                            raw_wd = i_item.item_value;
                        end
                        MODE_FILL: begin
                            pal_we = 1'b1;
                            pal_wd = i_item.item_value;
                        end
                        MODE_RD_WORD: begin
                            pk_re = i_item.item_index < r_word_cnt;
                            pk_ra = i_item.item_index[WORD_AW-1:0];
                        end
                        MODE_RD_PAL: begin
                            pal_re = i_item.item_index < INDEX_W'(r_pal_cnt);
                            pal_ra = i_item.item_index[PAL_AW-1:0];
                        end
                        MODE_RD_VALUE: begin
                            pal_re = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FA_RD: begin
                raw_re = 1'b1;
                raw_ra = r_i;
                pal_re = 1'b1;
            end
            S_FA_CMP: begin
                if (fa_miss && (r_cnt < limit)) begin
                    pal_we = 1'b1;
                    pal_wa = r_cnt[PAL_AW-1:0];
                    pal_wd = raw_rd;
                end
                if (fa_adv) begin
                    idx_we = 1'b1;
                    idx_wa = r_i;
                    idx_wd = fa_hit ? r_j[PAL_AW-1:0] : r_cnt[PAL_AW-1:0];
                    if (!last_i) begin
                        raw_re = 1'b1;
                        raw_ra = r_i + ENT_AW'(1);
                        pal_re = 1'b1;
                    end
                end else if (!fa_miss) begin
                    pal_re = 1'b1;
                    pal_ra = PAL_AW'(r_j + PCNT_W'(1));
                end
            end
            S_FB_RD: begin
                idx_re = (r_enc == ENC_INDIRECT);
                raw_re = (r_enc != ENC_INDIRECT);
                idx_ra = r_i;
                raw_ra = r_i;
            end
            S_FB_ACC: begin
                pk_we = fb_flush;
                pk_wa = r_w;
                pk_wd = word_next;
            end
            S_RV_CHK: begin
                pk_re = r_q < r_word_cnt;
                pk_ra = r_q[WORD_AW-1:0];
            end
            S_RV_EXT: begin
                pal_re = ext_v < VALUE_W'(r_pal_cnt);
                pal_ra = ext_v[PAL_AW-1:0];
            end
            default: begin
            end
        endcase
    end

    // raw value store
    always_ff @(posedge i_clk) begin
        if (raw_we) begin
            raw_mem[raw_wa] <= raw_wd;
        end
        if (raw_re) begin
            raw_rd <= raw_mem[raw_ra];
        end
    end

    // palette index of each entry
    always_ff @(posedge i_clk) begin
        if (idx_we) begin
            idx_mem[idx_wa] <= idx_wd;
        end
        if (idx_re) begin
            idx_rd <= idx_mem[idx_ra];
        end
    end

    // palette store, write data forwarded on a same-address read
    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            pal_mem[pal_wa] <= pal_wd;
        end
        if (pal_re) begin
            pal_rd     <= (pal_we && (pal_wa == pal_ra)) ? pal_wd : pal_mem[pal_ra];
            r_pal_zero <= (pal_ra == '0) && !r_p0_valid && !(pal_we && (pal_wa == '0));
        end
    end

    // packed word store
    always_ff @(posedge i_clk) begin
        if (pk_we) begin
            pk_mem[pk_wa] <= pk_wd;
        end
        if (pk_re) begin
            pk_rd <= pk_mem[pk_ra];
        end
    end

    // configuration, sequencer, container state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries  <= SIZE_W'(4096);
            r_kind     <= 1'b1;
            r_blk_min  <= 4'd4;
            r_blk_max  <= 6'd15;
            r_bio_min  <= 4'd1;
            r_bio_max  <= 6'd6;
            r_enc      <= ENC_SINGLE;
            r_bits     <= '0;
            r_pal_cnt  <= '0;
            r_word_cnt <= '0;
            r_load_pos <= '0;
            r_p0_valid <= 1'b0;
            r_state    <= S_IDLE;
            r_ov       <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ENTRIES:   r_entries <= i_cfg_data;
                    CFG_KIND:      r_kind    <= i_cfg_data[0];
                    CFG_BLOCK_MIN: r_blk_min <= i_cfg_data[3:0];
                    CFG_BLOCK_MAX: r_blk_max <= i_cfg_data[5:0];
                    CFG_BIOME_MIN: r_bio_min <= i_cfg_data[3:0];
                    CFG_BIOME_MAX: r_bio_max <= i_cfg_data[5:0];
                    default: begin
                    end
                endcase
            end

            if (pal_we && (pal_wa == '0)) begin
                r_p0_valid <= 1'b1;
            end

            // result word hand-off
            if ((r_state == S_DONE) && slot_free) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_res_data <= '0;
                        r_res_err  <= ERR_OK;
                        r_state    <= S_DONE;
                        case (i_item.mode)
                            MODE_LOAD: begin
                                if (r_load_pos < size) begin
                                    r_load_pos <= r_load_pos + SIZE_W'(1);
                                end else begin
                                    r_res_err <= ERR_RANGE;
                                end
                            end
                            MODE_FINALIZE: begin
                                r_load_pos <= '0;
                                if (r_load_pos != size) begin
                                    r_res_err <= ERR_COUNT;
                                end else begin
                                    r_i     <= '0;
                                    r_j     <= '0;
                                    r_cnt   <= '0;
                                    r_ovf   <= 1'b0;
                                    r_state <= S_FA_RD;
                                end
                            end
                            MODE_RD_VALUE: begin
                                if ({1'b0, i_item.item_index} >= size) begin
                                    r_res_err <= ERR_RANGE;
                                end else if (r_enc == ENC_SINGLE) begin
                                    r_state <= S_PAL_OUT;
                                end else begin
                                    r_q     <= i_item.item_index;
                                    r_rem   <= '0;
                                    r_k     <= '0;
                                    r_per   <= PER_TAB[r_bits];
                                    r_state <= S_RV_DIV;
                                end
                            end
                            MODE_RD_WORD: begin
                                if (i_item.item_index < r_word_cnt) begin
                                    r_state <= S_WORD_OUT;
                                end else begin
                                    r_res_err <= ERR_RANGE;
                                end
                            end
                            MODE_RD_PAL: begin
                                if (i_item.item_index < INDEX_W'(r_pal_cnt)) begin
                                    r_state <= S_PAL_OUT;
                                end else begin
                                    r_res_err <= ERR_RANGE;
                                end
                            end
                            MODE_FILL: begin
                                r_enc      <= ENC_SINGLE;
                                r_bits     <= '0;
                                r_pal_cnt  <= PCNT_W'(1);
                                r_word_cnt <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_FA_RD: begin
                    r_j     <= '0;
                    r_state <= S_FA_CMP;
                end
                // first-appearance palette search, one slot per cycle
                S_FA_CMP: begin
                    if (fa_adv) begin
                        if (fa_miss) begin
                            r_cnt <= r_cnt + PCNT_W'(1);
                        end
                        r_j <= '0;
                        if (last_i) begin
                            r_state <= S_FIN_DEC;
                        end else begin
                            r_i <= r_i + ENT_AW'(1);
                        end
                    end else if (fa_miss) begin
                        r_ovf   <= 1'b1;
                        r_state <= S_FIN_DEC;
                    end else begin
                        r_j <= r_j + PCNT_W'(1);
                    end
                end
                // pick the encoding
                S_FIN_DEC: begin
                    r_i    <= '0;
                    r_w    <= '0;
                    r_slot <= '0;
                    r_off  <= '0;
                    r_word <= '0;
                    if (!r_ovf && (r_cnt == PCNT_W'(1))) begin
                        r_enc      <= ENC_SINGLE;
                        r_bits     <= '0;
                        r_pal_cnt  <= PCNT_W'(1);
                        r_word_cnt <= '0;
                        r_state    <= S_DONE;
                    end else if (r_ovf) begin
                        r_enc     <= ENC_DIRECT;
                        r_bits    <= maxb;
                        r_pal_cnt <= '0;
                        r_per     <= PER_TAB[maxb];
                        r_state   <= S_FB_RD;
                    end else begin
                        r_enc     <= ENC_INDIRECT;
                        r_bits    <= new_bits;
                        r_pal_cnt <= r_cnt;
                        r_per     <= PER_TAB[new_bits];
                        r_state   <= S_FB_RD;
                    end
                end
                S_FB_RD: begin
                    r_state <= S_FB_ACC;
                end
                // pack one entry into the word being built
                S_FB_ACC: begin
                    if (fb_flush) begin
                        r_word <= '0;
                        r_slot <= '0;
                        r_off  <= '0;
                        r_w    <= r_w + WORD_AW'(1);
                    end else begin
                        r_word <= word_next;
                        r_slot <= r_slot + PER_W'(1);
                        r_off  <= r_off + r_bits;
                    end
                    if (fb_done) begin
                        r_word_cnt <= WCNT_W'(r_w) + WCNT_W'(1);
                        r_state    <= S_DONE;
                    end else begin
                        r_i     <= r_i + ENT_AW'(1);
                        r_state <= S_FB_RD;
                    end
                end
                // serial divide of the entry index by entries per word
                S_RV_DIV: begin
                    r_rem <= div_ge ? (rem_sh - r_per) : rem_sh;
                    r_q   <= {r_q[INDEX_W-2:0], div_ge};
                    r_k   <= r_k + 4'd1;
                    if (r_k == 4'(INDEX_W - 1)) begin
                        r_state <= S_RV_CHK;
                    end
                end
                S_RV_CHK: begin
                    r_off <= off_full[5:0];
                    if (r_q < r_word_cnt) begin
                        r_state <= S_RV_EXT;
                    end else begin
                        r_res_err <= ERR_RANGE;
                        r_state   <= S_DONE;
                    end
                end
                S_RV_EXT: begin
                    if (r_enc == ENC_INDIRECT) begin
                        if (ext_v < VALUE_W'(r_pal_cnt)) begin
                            r_state <= S_PAL_OUT;
                        end else begin
                            r_res_err <= ERR_RANGE;
                            r_state   <= S_DONE;
                        end
                    end else begin
                        r_res_data <= DATA_W'(ext_v);
                        r_state    <= S_DONE;
                    end
                end
                S_WORD_OUT: begin
                    r_res_data <= pk_rd;
                    r_state    <= S_DONE;
                end
                S_PAL_OUT: begin
                    r_res_data <= DATA_W'(pal_out);
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_o_data  <= r_res_data;
                        r_o_err   <= r_res_err;
                        r_o_enc   <= r_enc;
                        r_o_bits  <= r_bits;
                        r_o_pal   <= r_pal_cnt;
                        r_o_words <= r_word_cnt;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid         = r_ov;
    assign o_result.read_data     = r_o_data;
    assign o_result.error_code    = r_o_err;
    assign o_result.encoding_kind = r_o_enc;
    assign o_result.entry_bits    = r_o_bits;
    assign o_result.palette_size  = r_o_pal;
    assign o_result.word_total    = r_o_words;

endmodule
